[hw/rtl/sdll_pkg.sv]
// shared types and constants of the sorted linked list engine
package sdll_pkg;

  localparam int POOL = 64;
  localparam int IDX_W = 6;
  localparam int KEY_W = 16;
  localparam int DATA_W = 64;
  localparam int CAPACITY_DEF = 63;

  localparam logic [1:0] K_INSERT = 2'd0;
  localparam logic [1:0] K_REMOVE = 2'd1;
  localparam logic [1:0] K_LIST_FWD = 2'd2;
  localparam logic [1:0] K_LIST_BWD = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t prev;
    idx_t next;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0] data;
  } rec_t;

  typedef struct packed {
    logic next_en;
    idx_t next_addr;
    idx_t next_val;
    logic prev_en;
    idx_t prev_addr;
    idx_t prev_val;
    logic ent_en;
    idx_t ent_addr;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0] data;
  } wr_t;

endpackage

[hw/rtl/sorted_doubly_linked_list_engine.sv]
// top level of the sorted linked list engine
// Keeps up to CAPACITY keyed entries in ascending key order in a pool of linked
// records held in synchronous memories. Insert and remove walk the list from the
// head one record at a time, with a memory read and a compare per record visited,
// then splice on success, and give one result word. A list gives one word per
// entry; each entry takes a memory read, a capture and an output step, plus the
// wait on out_ready. One word is in work at a time, and listing a full pool is
// the longest item. No clearing pass is needed after reset.
module sorted_doubly_linked_list_engine import sdll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] kind,
  input  logic signed [KEY_W-1:0] key,
  input  logic [DATA_W-1:0] payload,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] status,
  output logic signed [KEY_W-1:0] entry_key,
  output logic [DATA_W-1:0] entry_payload,
  output logic last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WALK = 4'd1;
  localparam logic [3:0] S_WWAIT = 4'd2;
  localparam logic [3:0] S_DEC = 4'd3;
  localparam logic [3:0] S_FREE_RD = 4'd4;
  localparam logic [3:0] S_FREE_WT = 4'd5;
  localparam logic [3:0] S_INS1 = 4'd6;
  localparam logic [3:0] S_INS2 = 4'd7;
  localparam logic [3:0] S_REM1 = 4'd8;
  localparam logic [3:0] S_REM2 = 4'd9;
  localparam logic [3:0] S_LRD = 4'd10;
  localparam logic [3:0] S_LWT = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;

  logic [3:0] state;
  logic [1:0] op;
  logic signed [KEY_W-1:0] k;
  logic [DATA_W-1:0] pay;
  idx_t p, q, r, prv_p, nxt_p, steps, n;
  idx_t head_index, tail_index, free_head;
  logic match;
  idx_t rd_addr;
  rec_t rd;
  wr_t wr;
  idx_t nx;

  sdll_store #(.CAPACITY(CAPACITY)) u_store (
    .clk(clk), .rst(rst), .rd_addr(rd_addr), .rd(rd), .wr(wr)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign rd_addr = (state == S_FREE_RD) ? free_head : p;
  assign nx = (op == K_LIST_FWD) ? rd.next : rd.prev;

  always_comb begin
    wr = '0;
    case (state)
      S_INS1: begin
        wr.ent_en = 1'b1;
        wr.ent_addr = r;
        wr.key = k;
        wr.data = pay;
        wr.next_en = 1'b1;
        wr.next_addr = r;
        wr.next_val = p;
        wr.prev_en = 1'b1;
        wr.prev_addr = r;
        wr.prev_val = q;
      end
      S_INS2: begin
        wr.prev_en = (p != '0);
        wr.prev_addr = p;
        wr.prev_val = r;
        wr.next_en = (q != '0);
        wr.next_addr = q;
        wr.next_val = r;
      end
      S_REM1: begin
        wr.next_en = (prv_p != '0);
        wr.next_addr = prv_p;
        wr.next_val = nxt_p;
        wr.prev_en = (nxt_p != '0);
        wr.prev_addr = nxt_p;
        wr.prev_val = prv_p;
      end
      S_REM2: begin
        wr.next_en = 1'b1;
        wr.next_addr = p;
        wr.next_val = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head_index <= '0;
      tail_index <= '0;
      free_head <= idx_t'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= kind;
            k <= key;
            pay <= payload;
            steps <= '0;
            n <= '0;
            q <= '0;
            if (kind == K_INSERT || kind == K_REMOVE) begin
              p <= head_index;
              state <= S_WALK;
            end else begin
              p <= (kind == K_LIST_FWD) ? head_index : tail_index;
              if (((kind == K_LIST_FWD) ? head_index : tail_index) == '0) begin
                status <= ST_EMPTY;
                entry_key <= '0;
                entry_payload <= '0;
                last <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_LRD;
              end
            end
          end
        end
        S_WALK: begin
          if (p == '0 || steps >= idx_t'(CAPACITY)) begin
            p <= '0;
            match <= 1'b0;
            state <= S_DEC;
          end else begin
            state <= S_WWAIT;
          end
        end
        S_WWAIT: begin
          if (k > rd.key) begin
            q <= p;
            p <= rd.next;
            steps <= steps + idx_t'(1);
            state <= S_WALK;
          end else begin
            match <= (k == rd.key);
            prv_p <= rd.prev;
            nxt_p <= rd.next;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          entry_key <= '0;
          entry_payload <= '0;
          last <= 1'b1;
          if (op == K_INSERT) begin
            if (match) begin
              status <= ST_DUP;
              state <= S_OUT;
            end else if (free_head == '0) begin
              status <= ST_FULL;
              state <= S_OUT;
            end else begin
              state <= S_FREE_RD;
            end
          end else begin
            if (!match) begin
              status <= ST_MISSING;
              state <= S_OUT;
            end else begin
              state <= S_REM1;
            end
          end
        end
        S_FREE_RD: state <= S_FREE_WT;
        S_FREE_WT: begin
          r <= free_head;
          free_head <= rd.next;
          state <= S_INS1;
        end
        S_INS1: state <= S_INS2;
        S_INS2: begin
          if (p == '0) tail_index <= r;
          if (q == '0) head_index <= r;
          status <= ST_OK;
          state <= S_OUT;
        end
        S_REM1: begin
          if (prv_p == '0) head_index <= nxt_p;
          if (nxt_p == '0) tail_index <= prv_p;
          state <= S_REM2;
        end
        S_REM2: begin
          free_head <= p;
          status <= ST_OK;
          state <= S_OUT;
        end
        S_LRD: state <= S_LWT;
        S_LWT: begin
          status <= ST_OK;
          entry_key <= rd.key;
          entry_payload <= rd.data;
          last <= (nx == '0) || (({1'b0, n} + 7'd1) >= 7'(CAPACITY));
          p <= nx;
          n <= n + idx_t'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= last ? S_IDLE : S_LRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/sdll_store.sv]
// record pool memories with link reset through valid bits
module sdll_store import sdll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  idx_t rd_addr,
  output rec_t rd,
  input  wr_t  wr
);

  idx_t next_mem [POOL];
  idx_t prev_mem [POOL];
  logic signed [KEY_W-1:0] key_mem [POOL];
  logic [DATA_W-1:0] data_mem [POOL];
  logic [POOL-1:0] next_vld;
  logic [POOL-1:0] prev_vld;

  function automatic idx_t next_rst(input idx_t a);
    return (int'(a) < CAPACITY) ? idx_t'(a + idx_t'(1)) : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
      prev_vld <= '0;
    end else begin
      if (wr.next_en) next_vld[wr.next_addr] <= 1'b1;
      if (wr.prev_en) prev_vld[wr.prev_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.next_en) next_mem[wr.next_addr] <= wr.next_val;
    if (wr.prev_en) prev_mem[wr.prev_addr] <= wr.prev_val;
    if (wr.ent_en) begin
      key_mem[wr.ent_addr] <= wr.key;
      data_mem[wr.ent_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd.next <= next_vld[rd_addr] ? next_mem[rd_addr] : next_rst(rd_addr);
    rd.prev <= prev_vld[rd_addr] ? prev_mem[rd_addr] : '0;
    rd.key <= key_mem[rd_addr];
    rd.data <= data_mem[rd_addr];
  end

endmodule
